### hdl/int8mp_pkg.sv
// Shared types and constants for the int8 2D max pooling block.
// Used by the front end, command queue, back end and top level; no dependencies.
`default_nettype none

package int8mp_pkg;

  // Signed coordinate width for window positions
  localparam int unsigned POS_W = 13;

  // Configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_H  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_W  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_H  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_W  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_H     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_W     = 3'd7;

  // Action codes of an input item
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_POOL  = 1'b1;

  // Status codes of a result
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Starting value of the running maximum
  localparam logic signed [7:0] PIXEL_FLOOR = -8'sd128;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_POOL,
    CMD_ERROR
  } cmd_kind_e;

  // Effective configuration after clamping
  typedef struct packed {
    logic [6:0] height;
    logic [6:0] width;
    logic [3:0] kh;
    logic [3:0] kw;
    logic [3:0] sh;
    logic [3:0] sw;
    logic [2:0] ph;
    logic [2:0] pw;
  } cfg_t;

  // Classified command from front end to back end
  typedef struct packed {
    cmd_kind_e               kind;
    logic signed [POS_W-1:0] row;
    logic signed [POS_W-1:0] col;
    logic [7:0]              pixel;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/int8mp_front.sv
// Front end: takes input items, checks coordinates and output bounds, and
// queues store, pool or error commands. Depends on int8mp_pkg.
`default_nettype none

module int8mp_front #(
  parameter int DIL_H = 1,
  parameter int DIL_W = 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  int8mp_pkg::cfg_t     cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  action_i,
  input  wire  [5:0]           in_row_i,
  input  wire  [5:0]           in_col_i,
  input  wire  signed [7:0]    pixel_value_i,
  input  wire  [6:0]           out_row_i,
  input  wire  [6:0]           out_col_i,
  output logic                 push_o,
  output int8mp_pkg::cmd_t     cmd_o,
  input  wire                  full_i
);

  localparam int unsigned PW = int8mp_pkg::POS_W;

  logic              stg_valid_q, stg_valid_d;
  logic              action_q;
  logic [5:0]        in_row_q, in_col_q;
  logic [7:0]        pixel_q;
  logic [6:0]        out_row_q, out_col_q;

  logic              accept;
  logic              store_ok;
  logic              drop;
  logic              consume;
  logic [10:0]       prod_r, prod_c;
  logic [PW-1:0]     span_h, span_w;
  logic signed [PW-1:0] num_h, num_w;
  logic              row_ok, col_ok;

  assign accept = in_valid_i && !in_stall_o;

  // Input stage: hold one item while it is classified
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q  <= action_i;
      in_row_q  <= in_row_i;
      in_col_q  <= in_col_i;
      pixel_q   <= pixel_value_i;
      out_row_q <= out_row_i;
      out_col_q <= out_col_i;
    end
  end

  // Store lands only inside the plane in use
  assign store_ok = ({1'b0, in_row_q} < cfg_i.height) && ({1'b0, in_col_q} < cfg_i.width);

  // Output bounds: coordinate*stride must not pass the last window start
  assign span_h = PW'(DIL_H * int'(cfg_i.kh - 4'd1));
  assign span_w = PW'(DIL_W * int'(cfg_i.kw - 4'd1));
  assign num_h  = $signed(PW'(cfg_i.height)) + $signed(PW'({cfg_i.ph, 1'b0}))
                - $signed(span_h) - $signed(PW'(1));
  assign num_w  = $signed(PW'(cfg_i.width)) + $signed(PW'({cfg_i.pw, 1'b0}))
                - $signed(span_w) - $signed(PW'(1));
  assign prod_r = 11'(out_row_q) * 11'(cfg_i.sh);
  assign prod_c = 11'(out_col_q) * 11'(cfg_i.sw);
  assign row_ok = !num_h[PW-1] && ($signed(PW'(prod_r)) <= num_h);
  assign col_ok = !num_w[PW-1] && ($signed(PW'(prod_c)) <= num_w);

  // Classify the staged item
  always_comb begin
    cmd_o = '0;
    drop  = 1'b0;
    if (action_q == int8mp_pkg::ACT_STORE) begin
      cmd_o.kind  = int8mp_pkg::CMD_STORE;
      cmd_o.row   = $signed(PW'(in_row_q));
      cmd_o.col   = $signed(PW'(in_col_q));
      cmd_o.pixel = pixel_q;
      drop        = !store_ok;
    end else if (row_ok && col_ok) begin
      cmd_o.kind = int8mp_pkg::CMD_POOL;
      cmd_o.row  = $signed(PW'(prod_r)) - $signed(PW'(cfg_i.ph));
      cmd_o.col  = $signed(PW'(prod_c)) - $signed(PW'(cfg_i.pw));
    end else begin
      cmd_o.kind = int8mp_pkg::CMD_ERROR;
    end
  end

  assign consume    = stg_valid_q && (drop || !full_i);
  assign push_o     = stg_valid_q && !drop && !full_i;
  assign in_stall_o = stg_valid_q && !consume;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (consume) begin
      stg_valid_d = 1'b0;
    end
    if (accept) begin
      stg_valid_d = 1'b1;
    end
  end

endmodule

`default_nettype wire

### hdl/int8mp_fifo.sv
// Two-entry command queue between front end and back end.
// Depends on int8mp_pkg for the command type.
`default_nettype none

module int8mp_fifo (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  int8mp_pkg::cmd_t  cmd_i,
  output logic              full_o,
  input  wire               pop_i,
  output int8mp_pkg::cmd_t  cmd_o,
  output logic              empty_o
);

  int8mp_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### hdl/int8mp_back.sv
// Back end: owns the plane store, writes pixels and walks pooling windows
// one position per cycle, then holds the result for transfer. Depends on int8mp_pkg.
`default_nettype none

module int8mp_back #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64,
  parameter int DIL_H      = 1,
  parameter int DIL_W      = 1
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  int8mp_pkg::cfg_t    cfg_i,
  input  int8mp_pkg::cmd_t    cmd_i,
  input  wire                 cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic signed [7:0]   max_value_o,
  output logic                status_o
);

  localparam int unsigned PW    = int8mp_pkg::POS_W;
  localparam int          DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int          AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [7:0] mem [DEPTH];

  logic [1:0]           state_q, state_d;
  logic [3:0]           i_q, i_d, j_q, j_d;
  logic signed [PW-1:0] base_r_q, base_r_d, base_c_q, base_c_d;
  logic signed [7:0]    m_q, m_d;
  logic                 pend_q, pend_d;
  logic [7:0]           rdata_q;
  logic                 out_valid_q, out_valid_d;
  logic signed [7:0]    out_max_q, out_max_d;
  logic                 out_status_q, out_status_d;

  logic                 out_free;
  logic                 out_load;
  logic                 we, rd_en;
  logic signed [PW-1:0] pos_r, pos_c;
  logic                 pos_ok;
  logic [AW-1:0]        waddr, raddr;

  assign out_free = !out_valid_q || !out_stall_i;

  // Current window position
  assign pos_r  = base_r_q + $signed(PW'(DIL_H * int'(i_q)));
  assign pos_c  = base_c_q + $signed(PW'(DIL_W * int'(j_q)));
  assign pos_ok = !pos_r[PW-1] && (pos_r < $signed(PW'(cfg_i.height)))
               && !pos_c[PW-1] && (pos_c < $signed(PW'(cfg_i.width)));

  assign raddr = AW'(32'(pos_r[PW-2:0]) * 32'(MAX_WIDTH) + 32'(pos_c[PW-2:0]));
  assign waddr = AW'(32'(cmd_i.row[PW-2:0]) * 32'(MAX_WIDTH) + 32'(cmd_i.col[PW-2:0]));

  // Plane store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= cmd_i.pixel;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    base_r_d     = base_r_q;
    base_c_d     = base_c_q;
    m_d          = m_q;
    pend_d       = 1'b0;
    cmd_pop_o    = 1'b0;
    we           = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_max_d    = out_max_q;
    out_status_d = out_status_q;

    // Fold the pixel read in the previous cycle
    if (pend_q && ($signed(rdata_q) > m_q)) begin
      m_d = $signed(rdata_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            int8mp_pkg::CMD_STORE: begin
              we        = 1'b1;
              cmd_pop_o = 1'b1;
            end
            int8mp_pkg::CMD_POOL: begin
              cmd_pop_o = 1'b1;
              base_r_d  = cmd_i.row;
              base_c_d  = cmd_i.col;
              i_d       = 4'd0;
              j_d       = 4'd0;
              m_d       = int8mp_pkg::PIXEL_FLOOR;
              state_d   = ST_WALK;
            end
            int8mp_pkg::CMD_ERROR: begin
              if (out_free) begin
                cmd_pop_o    = 1'b1;
                out_load     = 1'b1;
                out_max_d    = 8'sd0;
                out_status_d = int8mp_pkg::STATUS_ERR;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        rd_en  = pos_ok;
        pend_d = pos_ok;
        if (j_q == cfg_i.kw - 4'd1) begin
          j_d = 4'd0;
          if (i_q == cfg_i.kh - 4'd1) begin
            state_d = ST_LAST;
          end else begin
            i_d = i_q + 4'd1;
          end
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      ST_LAST: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_max_d    = m_q;
          out_status_d = int8mp_pkg::STATUS_OK;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: hold until transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    base_r_q     <= base_r_d;
    base_c_q     <= base_c_d;
    m_q          <= m_d;
    out_max_q    <= out_max_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign max_value_o = out_max_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

### hdl/int8_max_pool_2d_top.sv
// Int8 2D max pooling top: config registers, front end, command queue, back end.
// Store item: staged and queued; the back end writes the pixel when it takes it.
// Pool item: the back end walks the window (one store read per window position),
//   then loads the result register. Error result: loaded without a walk.
// Reset (async, active low) clears control state and loads register defaults;
//   plane store contents are undefined until written.
`default_nettype none

module int8_max_pool_2d_top #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_KERNEL = 8,
  parameter int DIL_H      = 1,
  parameter int DIL_W      = 1
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [int8mp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [int8mp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire                                   action_i,
  input  wire  [5:0]                            in_row_i,
  input  wire  [5:0]                            in_col_i,
  input  wire  signed [7:0]                     pixel_value_i,
  input  wire  [6:0]                            out_row_i,
  input  wire  [6:0]                            out_col_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [7:0]                     max_value_o,
  output logic                                  status_o
);

  logic [6:0] in_height_q, in_width_q;
  logic [3:0] kernel_h_q, kernel_w_q, stride_h_q, stride_w_q;
  logic [2:0] pad_h_q, pad_w_q;

  int8mp_pkg::cfg_t cfg;
  int8mp_pkg::cmd_t front_cmd, queue_cmd;
  logic             push, full, pop, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q <= 7'd64;
      in_width_q  <= 7'd64;
      kernel_h_q  <= 4'd2;
      kernel_w_q  <= 4'd2;
      stride_h_q  <= 4'd2;
      stride_w_q  <= 4'd2;
      pad_h_q     <= 3'd0;
      pad_w_q     <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        int8mp_pkg::CFG_IN_HEIGHT: in_height_q <= cfg_wdata_i[6:0];
        int8mp_pkg::CFG_IN_WIDTH:  in_width_q  <= cfg_wdata_i[6:0];
        int8mp_pkg::CFG_KERNEL_H:  kernel_h_q  <= cfg_wdata_i[3:0];
        int8mp_pkg::CFG_KERNEL_W:  kernel_w_q  <= cfg_wdata_i[3:0];
        int8mp_pkg::CFG_STRIDE_H:  stride_h_q  <= cfg_wdata_i[3:0];
        int8mp_pkg::CFG_STRIDE_W:  stride_w_q  <= cfg_wdata_i[3:0];
        int8mp_pkg::CFG_PAD_H:     pad_h_q     <= cfg_wdata_i[2:0];
        int8mp_pkg::CFG_PAD_W:     pad_w_q     <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes, kernels and strides to their usable range
  always_comb begin
    cfg.height = (32'(in_height_q) > 32'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : in_height_q;
    cfg.width  = (32'(in_width_q) > 32'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : in_width_q;
    if (kernel_h_q == 4'd0) begin
      cfg.kh = 4'd1;
    end else if (32'(kernel_h_q) > 32'(MAX_KERNEL)) begin
      cfg.kh = 4'(MAX_KERNEL);
    end else begin
      cfg.kh = kernel_h_q;
    end
    if (kernel_w_q == 4'd0) begin
      cfg.kw = 4'd1;
    end else if (32'(kernel_w_q) > 32'(MAX_KERNEL)) begin
      cfg.kw = 4'(MAX_KERNEL);
    end else begin
      cfg.kw = kernel_w_q;
    end
    cfg.sh = (stride_h_q == 4'd0) ? 4'd1 : stride_h_q;
    cfg.sw = (stride_w_q == 4'd0) ? 4'd1 : stride_w_q;
    cfg.ph = pad_h_q;
    cfg.pw = pad_w_q;
  end

  int8mp_front #(
    .DIL_H (DIL_H),
    .DIL_W (DIL_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .in_row_i      (in_row_i),
    .in_col_i      (in_col_i),
    .pixel_value_i (pixel_value_i),
    .out_row_i     (out_row_i),
    .out_col_i     (out_col_i),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .full_i        (full)
  );

  int8mp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (empty)
  );

  int8mp_back #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .DIL_H      (DIL_H),
    .DIL_W      (DIL_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (empty),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .max_value_o (max_value_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

### hdl/int8mp_checker.sv
// Port-level checks for the int8 max pooling top, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module int8mp_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_stall_o,
  input wire              out_valid_o,
  input wire              out_stall_i,
  input wire signed [7:0] max_value_o,
  input wire              status_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(max_value_o) && $stable(status_o))
    else $error("stalled result changed");

  // Error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> max_value_o == 8'sd0)
    else $error("error result with nonzero value");

  // Leave reset empty and ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_stall_o && !out_valid_o)
    else $error("block busy right after reset");

endmodule

bind int8_max_pool_2d_top int8mp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .max_value_o (max_value_o),
  .status_o    (status_o)
);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the int8 2D max pooling block (int8_max_pool_2d_top).
// Holds its own pooling predictor and plane copy; depends only on int8mp_pkg and the top.
// Directed table first, then phases of random stores and pools under changing settings.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_H        = 64;
  localparam int MAX_W        = 64;
  localparam int MAX_K        = 8;
  localparam int DIL_H        = 1;
  localparam int DIL_W        = 1;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_FIXED    = 8;

  typedef struct packed {
    logic signed [7:0] max_value;
    logic              status;
  } pool_res_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_STORE,
    ROW_POOL
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [6:0]  a;      // row, output row or register index
    logic [6:0]  b;      // column or output column
    logic [7:0]  v;      // pixel or register value
    logic        typed;  // expected result given in the row
    pool_res_t   res;
  } dir_row_t;

  // DUT ports
  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              cfg_we    = 1'b0;
  logic [int8mp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [int8mp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic                              action    = int8mp_pkg::ACT_STORE;
  logic [5:0]                        in_row    = '0;
  logic [5:0]                        in_col    = '0;
  logic signed [7:0]                 pixel     = '0;
  logic [6:0]                        out_row   = '0;
  logic [6:0]                        out_col   = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [7:0]                 max_value;
  logic                              status;

  // Result typed into the directed table, travels with the driven item
  logic      drv_typed     = 1'b0;
  pool_res_t drv_typed_res = '0;

  // Predictor state
  logic [6:0] reg_shadow [8];
  logic [7:0] plane [MAX_H*MAX_W];
  bit         plane_written [MAX_H*MAX_W];
  pool_res_t  pooled_q [$];

  dir_row_t   directed_rows [$];
  logic [6:0] phase_cfg [NUM_FIXED][8];
  logic [6:0] cfg_plan [8];

  int mismatches     = 0;
  int items_sent     = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;

  int8_max_pool_2d_top #(
    .MAX_HEIGHT(MAX_H),
    .MAX_WIDTH (MAX_W),
    .MAX_KERNEL(MAX_K),
    .DIL_H     (DIL_H),
    .DIL_W     (DIL_W)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .in_row_i     (in_row),
    .in_col_i     (in_col),
    .pixel_value_i(pixel),
    .out_row_i    (out_row),
    .out_col_i    (out_col),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .max_value_o  (max_value),
    .status_o     (status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pooling predictor
  // ---------------------------------------------------------------------------

  // Keep only the bits that a register holds
  function automatic logic [6:0] reg_mask(logic [2:0] idx, logic [6:0] val);
    case (idx) inside
      int8mp_pkg::CFG_IN_HEIGHT, int8mp_pkg::CFG_IN_WIDTH: return val;
      int8mp_pkg::CFG_PAD_H, int8mp_pkg::CFG_PAD_W:        return val & 7'h07;
      default:                                             return val & 7'h0f;
    endcase
  endfunction

  function automatic int plane_rows();
    return (reg_shadow[int8mp_pkg::CFG_IN_HEIGHT] > MAX_H) ? MAX_H
                                                           : int'(reg_shadow[int8mp_pkg::CFG_IN_HEIGHT]);
  endfunction

  function automatic int plane_cols();
    return (reg_shadow[int8mp_pkg::CFG_IN_WIDTH] > MAX_W) ? MAX_W
                                                          : int'(reg_shadow[int8mp_pkg::CFG_IN_WIDTH]);
  endfunction

  function automatic int win_size(logic [6:0] k);
    if (k == 0) return 1;
    return (k > MAX_K) ? MAX_K : int'(k);
  endfunction

  function automatic int step_size(logic [6:0] s);
    return (s == 0) ? 1 : int'(s);
  endfunction

  function automatic int out_dim(int n, int pad, int dil, int k, int s);
    int num;
    num = n + 2 * pad - dil * (k - 1) - 1;
    if (num < 0) return 0;
    return num / s + 1;
  endfunction

  function automatic int out_rows();
    return out_dim(plane_rows(), int'(reg_shadow[int8mp_pkg::CFG_PAD_H]), DIL_H,
                   win_size(reg_shadow[int8mp_pkg::CFG_KERNEL_H]),
                   step_size(reg_shadow[int8mp_pkg::CFG_STRIDE_H]));
  endfunction

  function automatic int out_cols();
    return out_dim(plane_cols(), int'(reg_shadow[int8mp_pkg::CFG_PAD_W]), DIL_W,
                   win_size(reg_shadow[int8mp_pkg::CFG_KERNEL_W]),
                   step_size(reg_shadow[int8mp_pkg::CFG_STRIDE_W]));
  endfunction

  // Write a pixel unless it falls outside the plane in use
  function automatic void store_pixel(int r, int c, logic [7:0] px);
    if (r < plane_rows() && c < plane_cols()) begin
      plane[r*MAX_W + c]         = px;
      plane_written[r*MAX_W + c] = 1'b1;
    end
  endfunction

  // Walk the window at an output coordinate, skipping padded positions
  function automatic pool_res_t window_max(int orow, int ocol);
    int        kh, kw, sh, sw, ph, pw, r, c, i, j, best, v;
    pool_res_t res;
    kh = win_size(reg_shadow[int8mp_pkg::CFG_KERNEL_H]);
    kw = win_size(reg_shadow[int8mp_pkg::CFG_KERNEL_W]);
    sh = step_size(reg_shadow[int8mp_pkg::CFG_STRIDE_H]);
    sw = step_size(reg_shadow[int8mp_pkg::CFG_STRIDE_W]);
    ph = int'(reg_shadow[int8mp_pkg::CFG_PAD_H]);
    pw = int'(reg_shadow[int8mp_pkg::CFG_PAD_W]);
    if (orow >= out_rows() || ocol >= out_cols()) begin
      res.max_value = '0;
      res.status    = int8mp_pkg::STATUS_ERR;
      return res;
    end
    best = -128;
    for (i = 0; i < kh; i++) begin
      r = orow * sh - ph + i * DIL_H;
      if (r < 0 || r >= plane_rows()) continue;
      for (j = 0; j < kw; j++) begin
        c = ocol * sw - pw + j * DIL_W;
        if (c < 0 || c >= plane_cols()) continue;
        v = int'($signed(plane[r*MAX_W + c]));
        if (v > best) best = v;
      end
    end
    res.max_value = best[7:0];
    res.status    = int8mp_pkg::STATUS_OK;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic dir_row_t dreg(logic [2:0] idx, int val);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.a    = 7'(idx);
    row.v    = 8'(val);
    return row;
  endfunction

  function automatic dir_row_t dstore(int r, int c, int px);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_STORE;
    row.a    = 7'(r);
    row.b    = 7'(c);
    row.v    = 8'(px);
    return row;
  endfunction

  function automatic dir_row_t dpool(int orow, int ocol);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_POOL;
    row.a    = 7'(orow);
    row.b    = 7'(ocol);
    return row;
  endfunction

  function automatic dir_row_t dpool_is(int orow, int ocol, int mx, logic st);
    dir_row_t row;
    row               = dpool(orow, ocol);
    row.typed         = 1'b1;
    row.res.max_value = 8'(mx);
    row.res.status    = st;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap and hold it until the transfer.
  // Returns at the next falling edge with valid still high.
  task automatic send_item(input logic act, input logic [5:0] r, input logic [5:0] c,
                           input logic [7:0] px, input logic [6:0] orow,
                           input logic [6:0] ocol, input logic typed,
                           input pool_res_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    in_row        <= r;
    in_col        <= c;
    pixel         <= px;
    out_row       <= orow;
    out_col       <= ocol;
    drv_typed     <= typed;
    drv_typed_res <= typed_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_store(input int r, input int c, input logic [7:0] px);
    send_item(int8mp_pkg::ACT_STORE, 6'(r), 6'(c), px, 7'($urandom), 7'($urandom),
              1'b0, '0);
  endtask

  // Fill any unwritten in-plane window entries, then issue the pool
  task automatic pool_at(input int orow, input int ocol);
    int kh, kw, sh, sw, r, c, i, j;
    kh = win_size(reg_shadow[int8mp_pkg::CFG_KERNEL_H]);
    kw = win_size(reg_shadow[int8mp_pkg::CFG_KERNEL_W]);
    sh = step_size(reg_shadow[int8mp_pkg::CFG_STRIDE_H]);
    sw = step_size(reg_shadow[int8mp_pkg::CFG_STRIDE_W]);
    if (orow < out_rows() && ocol < out_cols()) begin
      for (i = 0; i < kh; i++) begin
        r = orow * sh - int'(reg_shadow[int8mp_pkg::CFG_PAD_H]) + i * DIL_H;
        if (r < 0 || r >= plane_rows()) continue;
        for (j = 0; j < kw; j++) begin
          c = ocol * sw - int'(reg_shadow[int8mp_pkg::CFG_PAD_W]) + j * DIL_W;
          if (c < 0 || c >= plane_cols()) continue;
          if (!plane_written[r*MAX_W + c]) send_store(r, c, 8'($urandom));
        end
      end
    end
    send_item(int8mp_pkg::ACT_POOL, 6'($urandom), 6'($urandom), 8'($urandom), 7'(orow),
              7'(ocol), 1'b0, '0);
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pooled_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Drive one register write; the caller lowers the write enable
  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    cfg_we          <= 1'b1;
    cfg_index       <= idx;
    cfg_wdata       <= val;
    reg_shadow[idx]  = reg_mask(idx, val);
    @(negedge clk);
  endtask

  // Write all registers from cfg_plan, with junk in the unused upper bits
  task automatic apply_config();
    int i;
    wait_idle();
    for (i = 0; i < 8; i++)
      write_reg(3'(i), cfg_plan[i] | (7'($urandom) & ~reg_mask(3'(i), 7'h7f)));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left == 0 && hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Check results, then predict from the input transfer at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pool_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pooled_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got max_value %0d status %0b",
                   $time, max_value, status);
          mismatches++;
        end else begin
          want = pooled_q.pop_front();
          if (max_value !== want.max_value) begin
            $display("%0t: max_value mismatch: expected %0d, got %0d",
                     $time, want.max_value, max_value);
            mismatches++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0b, got %0b",
                     $time, want.status, status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (action == int8mp_pkg::ACT_STORE) store_pixel(int'(in_row), int'(in_col), pixel);
        else pooled_q.push_back(drv_typed ? drv_typed_res :
                                window_max(int'(out_row), int'(out_col)));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pooled_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    int       phase, start, pick, oh, ow, h, w, i;

    reg_shadow = '{7'd64, 7'd64, 7'd2, 7'd2, 7'd2, 7'd2, 7'd0, 7'd0};

    // Reset settings: 64x64 plane, 2x2 window, stride 2, no padding
    directed_rows = '{
      dstore(0, 0, 127), dstore(0, 1, -128), dstore(1, 0, 0), dstore(1, 1, -1),
      dpool_is(0, 0, 127, int8mp_pkg::STATUS_OK),
      dstore(63, 63, -128), dstore(63, 62, -128), dstore(62, 63, -128),
      dstore(62, 62, -128),
      dpool_is(31, 31, -128, int8mp_pkg::STATUS_OK),
      // just past the output size, and the largest coordinates
      dpool_is(32, 0, 0, int8mp_pkg::STATUS_ERR), dpool_is(127, 127, 0, int8mp_pkg::STATUS_ERR),
      dpool_is(0, 32, 0, int8mp_pkg::STATUS_ERR),
      // 2x2 plane: a store outside it is dropped
      dreg(int8mp_pkg::CFG_IN_HEIGHT, 2), dreg(int8mp_pkg::CFG_IN_WIDTH, 2), dstore(5, 5, 55),
      // one row and column of padding on each side
      dreg(int8mp_pkg::CFG_PAD_H, 1), dreg(int8mp_pkg::CFG_PAD_W, 1),
      dpool_is(0, 0, 127, int8mp_pkg::STATUS_OK), dpool_is(1, 1, -1, int8mp_pkg::STATUS_OK),
      dpool_is(2, 0, 0, int8mp_pkg::STATUS_ERR),
      // empty plane: the window lies wholly in padding
      dreg(int8mp_pkg::CFG_IN_HEIGHT, 0), dpool_is(0, 1, -128, int8mp_pkg::STATUS_OK),
      // zero kernel and zero stride count as one
      dreg(int8mp_pkg::CFG_IN_HEIGHT, 2), dreg(int8mp_pkg::CFG_KERNEL_H, 0),
      dreg(int8mp_pkg::CFG_STRIDE_W, 0),
      dpool(1, 2)
    };

    // Settings per fixed phase: height, width, kh, kw, sh, sw, ph, pw
    phase_cfg = '{
      '{7'd8,   7'd8,   7'd2,  7'd2, 7'd2,  7'd2,  7'd0, 7'd0},
      '{7'd127, 7'd5,   7'd3,  7'd1, 7'd1,  7'd3,  7'd1, 7'd2},
      '{7'd1,   7'd1,   7'd1,  7'd1, 7'd1,  7'd1,  7'd0, 7'd0},
      '{7'd10,  7'd12,  7'd15, 7'd8, 7'd15, 7'd15, 7'd7, 7'd7},
      '{7'd0,   7'd127, 7'd2,  7'd3, 7'd0,  7'd2,  7'd3, 7'd0},
      '{7'd64,  7'd64,  7'd4,  7'd5, 7'd3,  7'd7,  7'd2, 7'd1},
      '{7'd127, 7'd127, 7'd1,  7'd1, 7'd1,  7'd1,  7'd7, 7'd7},
      '{7'd3,   7'd64,  7'd2,  7'd8, 7'd1,  7'd1,  7'd0, 7'd7}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      case (row.kind)
        ROW_REG: begin
          wait_idle();
          write_reg(row.a[2:0], row.v[6:0]);
          cfg_we <= 1'b0;
        end
        ROW_STORE: begin
          send_item(int8mp_pkg::ACT_STORE, row.a[5:0], row.b[5:0], row.v, 7'($urandom),
                    7'($urandom), 1'b0, '0);
        end
        default: begin
          send_item(int8mp_pkg::ACT_POOL, 6'($urandom), 6'($urandom), 8'($urandom), row.a,
                    row.b, row.typed, row.res);
        end
      endcase
    end

    // Random phases, each under its own settings and idling mode
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase < NUM_FIXED) begin
        cfg_plan = phase_cfg[phase];
      end else begin
        for (i = 0; i < 2; i++)
          cfg_plan[i] = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(1, 16))
                                                     : 7'($urandom_range(0, 127));
        for (i = 2; i < 4; i++)
          cfg_plan[i] = ($urandom_range(0, 99) < 75) ? 7'($urandom_range(1, 3))
                                                     : 7'($urandom_range(0, 15));
        for (i = 4; i < 6; i++)
          cfg_plan[i] = ($urandom_range(0, 99) < 75) ? 7'($urandom_range(1, 4))
                                                     : 7'($urandom_range(0, 15));
        for (i = 6; i < 8; i++)
          cfg_plan[i] = 7'($urandom_range(0, 7));
      end
      apply_config();

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      // Hold the output off while items keep coming, so the input backs up
      if (phase == 0) hold_req = HOLD_CYCLES;

      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        oh   = out_rows();
        ow   = out_cols();
        h    = plane_rows();
        w    = plane_cols();
        if (pick < 55 && oh > 0 && ow > 0)
          pool_at($urandom_range(0, oh - 1), $urandom_range(0, ow - 1));
        else if (pick < 70 && h > 0 && w > 0)
          send_store($urandom_range(0, h - 1), $urandom_range(0, w - 1), 8'($urandom));
        else if (pick < 85)
          send_store($urandom_range(0, 63), $urandom_range(0, 63), 8'($urandom));
        else
          pool_at($urandom_range(0, 127), $urandom_range(0, 127));
      end
      phase++;
    end

    // Drain and report
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
